// ===== rtl/mps_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, register indexes and controller states of the metric prefix scaler.
// Used by every module in rtl; depends on nothing else.
package mps_pkg;

  localparam int VALUE_BITS   = 64;
  localparam int PREFIX_COUNT = 8;

  localparam int DIVISOR_W  = 32;
  localparam int BASE_W     = 16;
  localparam int UNIT_W     = 8;
  localparam int WHOLE_W    = 64;
  localparam int FRAC_W     = 32;
  localparam int PREFIX_W   = 4;
  localparam int IN_TDATA_W = 64;

  localparam int OUT_FIELDS_W = WHOLE_W + FRAC_W + 1 + PREFIX_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  localparam int PROD_W    = VALUE_BITS + BASE_W;
  localparam int DIV_CNT_W = $clog2(VALUE_BITS);
  localparam int MUL_CNT_W = $clog2(BASE_W);
  localparam int STEP_W    = $clog2(PREFIX_COUNT + 2);

  localparam logic [BASE_W-1:0] FRAC_SCALE = BASE_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIVISOR,
    REG_BASE,
    REG_OMIT_ZERO,
    REG_UNIT_CHAR
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_Q,
    ST_MUL_PW,
    ST_LOOP,
    ST_FINAL,
    ST_WHOLE_GO,
    ST_DIV_W,
    ST_DIV_RB,
    ST_MUL_F,
    ST_DIV_F,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/mps_div.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle, VALUE_BITS quotient bits in all.
// Depends on mps_pkg.
module mps_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [mps_pkg::VALUE_BITS-1:0] dividend,
  input  logic [mps_pkg::VALUE_BITS-1:0] divisor,
  output logic                           busy,
  output logic                           done,
  output logic [mps_pkg::VALUE_BITS-1:0] quotient,
  output logic [mps_pkg::VALUE_BITS-1:0] remainder
);
  import mps_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] dvs_r, dvs_nxt;
  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS:0]   diff;
  logic                  fits;

  always_comb begin
    shifted  = {rem_r, quo_r[VALUE_BITS-1]};
    diff     = shifted - {1'b0, dvs_r};
    fits     = ~diff[VALUE_BITS];
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(VALUE_BITS - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[VALUE_BITS-2:0], fits};
      rem_nxt = fits ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/mps_mul.sv =====
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier: one bit of the narrow operand per cycle.
// Depends on mps_pkg.
module mps_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [mps_pkg::VALUE_BITS-1:0] mcand,
  input  logic [mps_pkg::BASE_W-1:0]     mplier,
  output logic                           busy,
  output logic                           done,
  output logic [mps_pkg::PROD_W-1:0]     product
);
  import mps_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [MUL_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] mcand_r, mcand_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [VALUE_BITS:0]   sum;

  always_comb begin
    sum = {1'b0, prod_r[PROD_W-1:BASE_W]} + (prod_r[0] ? {1'b0, mcand_r} : '0);
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    mcand_nxt = mcand_r;
    prod_nxt  = prod_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = MUL_CNT_W'(BASE_W - 1);
      mcand_nxt = mcand;
      prod_nxt  = {{VALUE_BITS{1'b0}}, mplier};
    end else if (busy_r) begin
      prod_nxt = {sum, prod_r[BASE_W-1:1]};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r <= mcand_nxt;
    prod_r  <= prod_nxt;
  end

  assign busy    = busy_r;
  assign done    = done_r;
  assign product = prod_r;

endmodule

// ===== rtl/metric_prefix_scaler_top.sv =====
`timescale 1ns / 1ps
// Top level of the metric prefix scaler: configuration registers, sequencer and output register.
// Depends on mps_pkg, mps_div and mps_mul.
//
// Channel  Role    Handshake               Payload
// in_      slave   in_tvalid / in_tready   in_tdata: value
// out_     master  out_tvalid / out_tready out_tdata, out_tuser: status
// cfg_     write   cfg_we                  cfg_index, cfg_wdata
//
// With a usable configuration a transaction runs up to four serial divisions in the shared
// divider and up to ten passes of the shared multiplier. A zero divisor or base skips the
// arithmetic: the sequencer goes straight to the output state with the error status set.
// Reset is synchronous and active low; the configuration returns to its reset values.
// A result waits in the output register while the next transaction is taken and worked on.
module metric_prefix_scaler_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mps_pkg::IN_TDATA_W-1:0]      in_tdata,   // [63:0] value
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [63:0] whole_part, [95:64] fraction, [96] show_fraction,
  // [100:97] prefix_index, [101] unit_shown, [103:102] zero
  output logic [mps_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tuser,  // [0] status
  input  logic                                cfg_we,
  input  logic [mps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mps_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import mps_pkg::*;

  state_t                state_r, state_nxt;
  logic [DIVISOR_W-1:0]  cfg_divisor_r, cfg_divisor_nxt;
  logic [BASE_W-1:0]     cfg_base_r, cfg_base_nxt;
  logic                  cfg_omit_r, cfg_omit_nxt;
  logic [UNIT_W-1:0]     cfg_unit_r, cfg_unit_nxt;

  logic [VALUE_BITS-1:0] q_r, q_nxt;
  logic [FRAC_W-1:0]     rem0_r, rem0_nxt;
  logic [VALUE_BITS-1:0] pw_r, pw_nxt;
  logic [VALUE_BITS-1:0] pw_prev_r, pw_prev_nxt;
  logic [VALUE_BITS-1:0] pw_prev2_r, pw_prev2_nxt;
  logic [VALUE_BITS-1:0] pw_fd_r, pw_fd_nxt;
  logic [VALUE_BITS-1:0] nxt_pw_r, nxt_pw_nxt;
  logic [STEP_W-1:0]     steps_r, steps_nxt;

  logic                  res_status_r, res_status_nxt;
  logic [VALUE_BITS-1:0] res_whole_r, res_whole_nxt;
  logic [FRAC_W-1:0]     res_frac_r, res_frac_nxt;
  logic                  res_show_r, res_show_nxt;
  logic [PREFIX_W-1:0]   res_prefix_r, res_prefix_nxt;
  logic                  res_unit_r, res_unit_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_user_r, out_user_nxt;

  logic                  div_start, div_busy, div_done;
  logic [VALUE_BITS-1:0] div_a, div_b, div_quo, div_rem;
  logic                  mul_start, mul_busy, mul_done;
  logic [VALUE_BITS-1:0] mul_a;
  logic [BASE_W-1:0]     mul_b;
  logic [PROD_W-1:0]     mul_prod;

  logic [VALUE_BITS-1:0] base_ext;
  logic                  out_load;
  logic [PREFIX_W-1:0]   out_prefix;
  logic                  out_unit;

  mps_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  mps_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .busy    (mul_busy),
    .done    (mul_done),
    .product (mul_prod)
  );

  assign base_ext  = VALUE_BITS'(cfg_base_r);
  assign in_tready = (state_r == ST_IDLE);
  assign out_load  = !out_valid_r || out_tready;

  always_comb begin
    cfg_divisor_nxt = cfg_divisor_r;
    cfg_base_nxt    = cfg_base_r;
    cfg_omit_nxt    = cfg_omit_r;
    cfg_unit_nxt    = cfg_unit_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_DIVISOR:   cfg_divisor_nxt = cfg_wdata[DIVISOR_W-1:0];
        REG_BASE:      cfg_base_nxt    = cfg_wdata[BASE_W-1:0];
        REG_OMIT_ZERO: cfg_omit_nxt    = cfg_wdata[0];
        REG_UNIT_CHAR: cfg_unit_nxt    = cfg_wdata[UNIT_W-1:0];
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    q_nxt          = q_r;
    rem0_nxt       = rem0_r;
    pw_nxt         = pw_r;
    pw_prev_nxt    = pw_prev_r;
    pw_prev2_nxt   = pw_prev2_r;
    pw_fd_nxt      = pw_fd_r;
    nxt_pw_nxt     = nxt_pw_r;
    steps_nxt      = steps_r;
    res_status_nxt = res_status_r;
    res_whole_nxt  = res_whole_r;
    res_frac_nxt   = res_frac_r;
    res_show_nxt   = res_show_r;
    res_prefix_nxt = res_prefix_r;
    res_unit_nxt   = res_unit_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    div_start      = 1'b0;
    div_a          = q_r;
    div_b          = pw_r;
    mul_start      = 1'b0;
    mul_a          = nxt_pw_r;
    mul_b          = cfg_base_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (cfg_divisor_r == '0 || cfg_base_r == '0) begin
            res_status_nxt = 1'b1;
            res_whole_nxt  = '0;
            res_frac_nxt   = '0;
            res_show_nxt   = 1'b0;
            res_prefix_nxt = '0;
            res_unit_nxt   = 1'b0;
            state_nxt      = ST_OUT;
          end else begin
            res_status_nxt = 1'b0;
            div_start      = 1'b1;
            div_a          = in_tdata[VALUE_BITS-1:0];
            div_b          = VALUE_BITS'(cfg_divisor_r);
            state_nxt      = ST_DIV_Q;
          end
        end
      end
      ST_DIV_Q: begin
        if (div_done) begin
          q_nxt     = div_quo;
          rem0_nxt  = div_rem[FRAC_W-1:0];
          pw_nxt    = base_ext;
          steps_nxt = '0;
          mul_start = 1'b1;
          mul_a     = base_ext;
          state_nxt = ST_MUL_PW;
        end
      end
      ST_MUL_PW: begin
        if (mul_done) begin
          nxt_pw_nxt = mul_prod[VALUE_BITS-1:0];
          // The next power would not fit, so the search stops here.
          if (mul_prod[PROD_W-1:VALUE_BITS] != '0) begin
            state_nxt = ST_FINAL;
          end else begin
            state_nxt = ST_LOOP;
          end
        end
      end
      ST_LOOP: begin
        if (q_r >= pw_r && steps_r < STEP_W'(PREFIX_COUNT)) begin
          pw_prev2_nxt = pw_prev_r;
          pw_prev_nxt  = pw_r;
          pw_nxt       = nxt_pw_r;
          steps_nxt    = steps_r + 1'b1;
          mul_start    = 1'b1;
          mul_a        = nxt_pw_r;
          state_nxt    = ST_MUL_PW;
        end else begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (pw_r != base_ext) begin
          if (q_r >= pw_r) begin
            steps_nxt = steps_r + 1'b1;
            pw_fd_nxt = pw_prev_r;
          end else begin
            pw_nxt    = pw_prev_r;
            pw_fd_nxt = pw_prev2_r;
          end
          state_nxt = ST_WHOLE_GO;
        end else begin
          res_whole_nxt  = q_r;
          res_frac_nxt   = rem0_r;
          res_show_nxt   = !(cfg_omit_r && rem0_r == '0);
          res_prefix_nxt = '0;
          res_unit_nxt   = 1'b0;
          state_nxt      = ST_OUT;
        end
      end
      ST_WHOLE_GO: begin
        div_start      = 1'b1;
        res_prefix_nxt = PREFIX_W'(steps_r);
        res_unit_nxt   = (cfg_unit_r != '0);
        state_nxt      = ST_DIV_W;
      end
      ST_DIV_W: begin
        if (div_done) begin
          res_whole_nxt = div_quo;
          if (cfg_omit_r && div_rem == '0) begin
            res_show_nxt = 1'b0;
            res_frac_nxt = '0;
            state_nxt    = ST_OUT;
          end else begin
            res_show_nxt = 1'b1;
            if (pw_r == base_ext) begin
              mul_start = 1'b1;
              mul_a     = div_rem;
              mul_b     = FRAC_SCALE;
              state_nxt = ST_MUL_F;
            end else begin
              div_start = 1'b1;
              div_a     = div_rem;
              div_b     = base_ext;
              state_nxt = ST_DIV_RB;
            end
          end
        end
      end
      ST_DIV_RB: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = div_quo;
          mul_b     = FRAC_SCALE;
          state_nxt = ST_MUL_F;
        end
      end
      ST_MUL_F: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_a     = mul_prod[VALUE_BITS-1:0];
          div_b     = (pw_r == base_ext) ? pw_r : pw_fd_r;
          state_nxt = ST_DIV_F;
        end
      end
      ST_DIV_F: begin
        if (div_done) begin
          res_frac_nxt = div_quo[FRAC_W-1:0];
          state_nxt    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_status_r;
          out_data_nxt  = {{OUT_PAD_W{1'b0}}, res_unit_r, res_prefix_r, res_show_r,
                           res_frac_r, WHOLE_W'(res_whole_r)};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      cfg_divisor_r <= DIVISOR_W'(1);
      cfg_base_r    <= BASE_W'(1000);
      cfg_omit_r    <= 1'b0;
      cfg_unit_r    <= '0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      cfg_divisor_r <= cfg_divisor_nxt;
      cfg_base_r    <= cfg_base_nxt;
      cfg_omit_r    <= cfg_omit_nxt;
      cfg_unit_r    <= cfg_unit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r          <= q_nxt;
    rem0_r       <= rem0_nxt;
    pw_r         <= pw_nxt;
    pw_prev_r    <= pw_prev_nxt;
    pw_prev2_r   <= pw_prev2_nxt;
    pw_fd_r      <= pw_fd_nxt;
    nxt_pw_r     <= nxt_pw_nxt;
    steps_r      <= steps_nxt;
    res_status_r <= res_status_nxt;
    res_whole_r  <= res_whole_nxt;
    res_frac_r   <= res_frac_nxt;
    res_show_r   <= res_show_nxt;
    res_prefix_r <= res_prefix_nxt;
    res_unit_r   <= res_unit_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_prefix = out_data_r[WHOLE_W+FRAC_W+1 +: PREFIX_W];
  assign out_unit   = out_data_r[WHOLE_W+FRAC_W+1+PREFIX_W];

  a_error_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error result carries nonzero fields");

  a_unit_needs_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_unit |-> out_prefix != '0)
    else $error("unit shown on an unscaled result");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

endmodule
